// File: hdl/hfmve_pkg.sv
// Shared types, constants and helpers for the height-field mesh vertex emitter.
`default_nettype none

package hfmve_pkg;

  localparam int unsigned COORD_W = 10;
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned POSY_W  = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_PITCH  = 2'd2;

  localparam logic [DIM_W-1:0]   GRID_HEIGHT_RST = 11'd256;
  localparam logic [PITCH_W-1:0] CELL_PITCH_RST  = 16'd255;

  // Coordinate math: 128.0 in Q.8 and the saturation thresholds on pitch*coord
  localparam logic [26:0] X_SAT_LIMIT = 27'd98303;
  localparam logic [26:0] Z_SAT_LIMIT = 27'd98304;
  localparam logic [17:0] HALF_SPAN   = 18'd32768;
  localparam logic [POS_W-1:0] POS_MAX_BITS = 17'h0FFFF;
  localparam logic [POS_W-1:0] POS_MIN_BITS = 17'h10000;

  // ceil(2^18 / 5): floor(v * RECIP5 >> 18) == v / 5 for v below 2^18
  localparam logic [15:0] RECIP5 = 16'd52429;

  localparam logic LIST_STRIP = 1'b0;
  localparam logic LIST_LINE  = 1'b1;

  // Bit 0 steps the column, bit 1 steps the row
  typedef enum logic [1:0] {
    CORNER_HERE  = 2'b00,
    CORNER_RIGHT = 2'b01,
    CORNER_BELOW = 2'b10,
    CORNER_DIAG  = 2'b11
  } corner_t;

  typedef enum logic [3:0] {
    ST_STRIP_HERE,
    ST_STRIP_BELOW,
    ST_STRIP_RIGHT,
    ST_LN_HERE0,
    ST_LN_RIGHT0,
    ST_LN_RIGHT1,
    ST_LN_DIAG0,
    ST_LN_DIAG1,
    ST_LN_BELOW0,
    ST_LN_BELOW1,
    ST_LN_HERE1,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_STRIP_DIAG
  } step_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   h_here;
    logic [PIX_W-1:0]   h_right;
    logic [PIX_W-1:0]   h_below;
    logic [PIX_W-1:0]   h_diag;
    logic               last_row;
    logic               odd;
  } cell_t;

  function automatic corner_t step_corner(input step_t s, input logic odd);
    corner_t c;
    case (s)
      ST_STRIP_HERE, ST_LN_HERE0, ST_LN_HERE1:   c = CORNER_HERE;
      ST_STRIP_BELOW, ST_LN_BELOW0, ST_LN_BELOW1: c = CORNER_BELOW;
      ST_STRIP_RIGHT, ST_LN_RIGHT0, ST_LN_RIGHT1: c = CORNER_RIGHT;
      ST_LN_DIAG0, ST_LN_DIAG1, ST_STRIP_DIAG:    c = CORNER_DIAG;
      ST_CROSS_A:  c = odd ? CORNER_RIGHT : CORNER_HERE;
      ST_CROSS_B:  c = odd ? CORNER_BELOW : CORNER_DIAG;
      default:     c = CORNER_HERE;
    endcase
    return c;
  endfunction

  function automatic logic step_list(input step_t s);
    logic l;
    case (s)
      ST_STRIP_HERE, ST_STRIP_BELOW, ST_STRIP_RIGHT, ST_STRIP_DIAG: l = LIST_STRIP;
      default: l = LIST_LINE;
    endcase
    return l;
  endfunction

endpackage

`default_nettype wire

// File: hdl/height_field_mesh_vertex_emitter_top.sv
// Top level of the height-field mesh vertex emitter: cell register, vertex sequencer, result register.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | col, row, four corner heights
//  out_    | output    | out_valid/out_stall| list_sel, pos_x, pos_y, pos_z, last
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A cell gives 12 to 14 vertices, one per cycle on the result channel while out_stall is low;
// the one-vertex-per-cycle result port sets how fast cells are taken.
// The next cell is taken in the same cycle its predecessor's last vertex is registered.
// Reset (rst_n low, synchronous) empties both registers and loads the register defaults.
// out_stall holds the result register and the sequencer; in_stall follows it combinationally.
`default_nettype none

module height_field_mesh_vertex_emitter_top #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,

  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [hfmve_pkg::COORD_W-1:0]      in_col,
  input  wire logic [hfmve_pkg::COORD_W-1:0]      in_row,
  input  wire logic [hfmve_pkg::PIX_W-1:0]        in_height_here,
  input  wire logic [hfmve_pkg::PIX_W-1:0]        in_height_right,
  input  wire logic [hfmve_pkg::PIX_W-1:0]        in_height_below,
  input  wire logic [hfmve_pkg::PIX_W-1:0]        in_height_diag,

  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_list_sel,
  output logic signed [hfmve_pkg::POS_W-1:0]      out_pos_x,
  output logic        [hfmve_pkg::POSY_W-1:0]     out_pos_y,
  output logic signed [hfmve_pkg::POS_W-1:0]      out_pos_z,
  output logic                                    out_last,

  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [hfmve_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hfmve_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import hfmve_pkg::*;

  localparam int unsigned GH_W = 13;

  logic [DIM_W-1:0]   grid_height_r;
  logic [PITCH_W-1:0] cell_pitch_r;

  cell_t cell_r, cell_nxt;
  logic  cell_vld_r, cell_vld_nxt;
  step_t step_r, step_nxt;

  logic              out_vld_r, out_vld_nxt;
  logic              out_sel_r;
  logic [POS_W-1:0]  out_x_r, out_z_r;
  logic [POSY_W-1:0] out_y_r;
  logic              out_last_r;

  logic              advance, step_last, accept;
  logic [GH_W-1:0]   gh_clamped;
  logic              in_last_row;
  corner_t           corner;
  logic [DIM_W-1:0]  cx, rz;
  logic [PIX_W-1:0]  pix;
  logic [26:0]       prod_x, prod_z;
  logic [17:0]       diff_x, diff_z;
  logic [POS_W-1:0]  pos_x_nxt, pos_z_nxt;
  logic [15:0]       y_num;
  logic [31:0]       y_prod;

  // Width register affects no vertex, so a write to it is taken and dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_height_r <= GRID_HEIGHT_RST;
      cell_pitch_r  <= CELL_PITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        CFG_CELL_PITCH:  cell_pitch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last-row flag of the incoming cell
  always_comb begin
    if ({2'b00, grid_height_r} > GH_W'(MAX_DIM)) begin
      gh_clamped = GH_W'(MAX_DIM);
    end else begin
      gh_clamped = {2'b00, grid_height_r};
    end
    in_last_row = (gh_clamped >= GH_W'(2)) &&
                  ({3'b000, in_row} == gh_clamped - GH_W'(2));
  end

  assign step_last = (step_r == ST_STRIP_DIAG) ||
                     (step_r == ST_CROSS_B && !cell_r.last_row);
  assign advance   = cell_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = cell_vld_r && !(advance && step_last);
  assign accept    = in_valid && !in_stall;

  always_comb begin
    cell_nxt     = cell_r;
    cell_vld_nxt = cell_vld_r;
    step_nxt     = step_r;
    if (accept) begin
      cell_nxt.col      = in_col;
      cell_nxt.row      = in_row;
      cell_nxt.h_here   = in_height_here;
      cell_nxt.h_right  = in_height_right;
      cell_nxt.h_below  = in_height_below;
      cell_nxt.h_diag   = in_height_diag;
      cell_nxt.last_row = in_last_row;
      cell_nxt.odd      = in_col[0] ^ in_row[0];
      cell_vld_nxt      = 1'b1;
      // Top strip vertex only on the first row
      step_nxt          = (in_row == '0) ? ST_STRIP_HERE : ST_STRIP_BELOW;
    end else if (advance && step_last) begin
      cell_vld_nxt = 1'b0;
    end else if (advance) begin
      step_nxt = (step_r == ST_CROSS_B) ? ST_STRIP_DIAG : step_t'(step_r + 4'd1);
    end
  end

  // Vertex datapath for the current step
  always_comb begin
    corner = step_corner(step_r, cell_r.odd);
    cx     = {1'b0, cell_r.col} + DIM_W'(corner[0]);
    rz     = {1'b0, cell_r.row} + DIM_W'(corner[1]);
    case (corner)
      CORNER_HERE:  pix = cell_r.h_here;
      CORNER_RIGHT: pix = cell_r.h_right;
      CORNER_BELOW: pix = cell_r.h_below;
      CORNER_DIAG:  pix = cell_r.h_diag;
      default:      pix = cell_r.h_here;
    endcase

    prod_x = 27'(cell_pitch_r) * 27'(cx);
    prod_z = 27'(cell_pitch_r) * 27'(rz);
    diff_x = {1'b0, prod_x[16:0]} - HALF_SPAN;
    diff_z = HALF_SPAN - {1'b0, prod_z[16:0]};
    pos_x_nxt = (prod_x > X_SAT_LIMIT) ? POS_MAX_BITS : diff_x[POS_W-1:0];
    pos_z_nxt = (prod_z > Z_SAT_LIMIT) ? POS_MIN_BITS : diff_z[POS_W-1:0];

    // Round 0.2 * pixel in Q.8: (pix*256 + 2) / 5 by reciprocal
    y_num  = {pix, 8'h02};
    y_prod = 32'(y_num) * 32'(RECIP5);
  end

  always_comb begin
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      step_r     <= ST_STRIP_HERE;
    end else begin
      cell_vld_r <= cell_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      step_r     <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (advance) begin
      out_sel_r  <= step_list(step_r);
      out_x_r    <= pos_x_nxt;
      out_z_r    <= pos_z_nxt;
      out_y_r    <= y_prod[31:18];
      out_last_r <= step_last;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_list_sel = out_sel_r;
  assign out_pos_x    = out_x_r;
  assign out_pos_y    = out_y_r;
  assign out_pos_z    = out_z_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the height-field mesh vertex emitter top level.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hfmve_pkg::*;

  localparam int unsigned MAX_DIM = 1024;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint POS_LO = -65536;
  localparam longint POS_HI = 65535;
  localparam longint ORIGIN_Q8 = 32768;

  typedef struct packed {
    logic                     list_sel;
    logic signed [POS_W-1:0]  pos_x;
    logic        [POSY_W-1:0] pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic                     last;
  } vertex_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   h_here;
    logic [PIX_W-1:0]   h_right;
    logic [PIX_W-1:0]   h_below;
    logic [PIX_W-1:0]   h_diag;
  } cell_in_t;

  class vertex_scoreboard;
    logic [DIM_W-1:0]   grid_width  = 11'd256;
    logic [DIM_W-1:0]   grid_height = GRID_HEIGHT_RST;
    logic [PITCH_W-1:0] cell_pitch  = CELL_PITCH_RST;
    vertex_t pending_vertices[$];
    int mismatches = 0;
    int vertices_checked = 0;
    int cells_noted = 0;

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_GRID_WIDTH:  grid_width = data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height = data[DIM_W-1:0];
        CFG_CELL_PITCH:  cell_pitch = data;
        default: ;
      endcase
    endfunction

    function logic signed [POS_W-1:0] clamp_pos(longint v);
      if (v < POS_LO) v = POS_LO;
      if (v > POS_HI) v = POS_HI;
      return v[POS_W-1:0];
    endfunction

    function vertex_t corner_vertex(longint cx, longint rz, logic [PIX_W-1:0] pix);
      vertex_t v;
      int unsigned scaled;
      scaled = (32'(pix) * 256 + 2) / 5;
      v.list_sel = LIST_STRIP;
      v.pos_x = clamp_pos(longint'(cell_pitch) * cx - ORIGIN_Q8);
      v.pos_y = scaled[POSY_W-1:0];
      v.pos_z = clamp_pos(ORIGIN_Q8 - longint'(cell_pitch) * rz);
      v.last = 1'b0;
      return v;
    endfunction

    function vertex_t tag(logic sel, vertex_t v);
      v.list_sel = sel;
      return v;
    endfunction

    // Append one expected vertex behind everything already pending
    function void queue_vertex(logic sel, vertex_t v);
      pending_vertices.insert(pending_vertices.size(), tag(sel, v));
    endfunction

    function void note_cell(cell_in_t c);
      int unsigned gh;
      bit last_row;
      vertex_t here, right, below, diag;
      gh = (grid_height > MAX_DIM) ? MAX_DIM : grid_height;
      last_row = (gh >= 2) && (c.row == gh - 2);
      here  = corner_vertex(longint'(c.col),     longint'(c.row),     c.h_here);
      right = corner_vertex(longint'(c.col) + 1, longint'(c.row),     c.h_right);
      below = corner_vertex(longint'(c.col),     longint'(c.row) + 1, c.h_below);
      diag  = corner_vertex(longint'(c.col) + 1, longint'(c.row) + 1, c.h_diag);
      if (c.row == 0) queue_vertex(LIST_STRIP, here);
      queue_vertex(LIST_STRIP, below);
      queue_vertex(LIST_STRIP, right);
      queue_vertex(LIST_LINE, here);
      queue_vertex(LIST_LINE, right);
      queue_vertex(LIST_LINE, right);
      queue_vertex(LIST_LINE, diag);
      queue_vertex(LIST_LINE, diag);
      queue_vertex(LIST_LINE, below);
      queue_vertex(LIST_LINE, below);
      queue_vertex(LIST_LINE, here);
      // diagonal direction follows the parity of col+row
      if ((c.col[0] ^ c.row[0]) == 1'b0) begin
        queue_vertex(LIST_LINE, here);
        queue_vertex(LIST_LINE, diag);
      end else begin
        queue_vertex(LIST_LINE, right);
        queue_vertex(LIST_LINE, below);
      end
      if (last_row) queue_vertex(LIST_STRIP, diag);
      pending_vertices[pending_vertices.size()-1].last = 1'b1;
      cells_noted++;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t want;
      if (pending_vertices.size() == 0) begin
        $error("vertex transfer with nothing expected: x=%0d y=%0d z=%0d",
               got.pos_x, got.pos_y, got.pos_z);
        mismatches++;
        return;
      end
      want = pending_vertices.pop_front();
      vertices_checked++;
      if (got.list_sel !== want.list_sel) begin
        $error("list_sel: expected %0d, got %0d", want.list_sel, got.list_sel);
        mismatches++;
      end
      if (got.pos_x !== want.pos_x) begin
        $error("pos_x: expected %0d, got %0d", want.pos_x, got.pos_x);
        mismatches++;
      end
      if (got.pos_y !== want.pos_y) begin
        $error("pos_y: expected %0d, got %0d", want.pos_y, got.pos_y);
        mismatches++;
      end
      if (got.pos_z !== want.pos_z) begin
        $error("pos_z: expected %0d, got %0d", want.pos_z, got.pos_z);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic [PIX_W-1:0] in_height_here;
  logic [PIX_W-1:0] in_height_right;
  logic [PIX_W-1:0] in_height_below;
  logic [PIX_W-1:0] in_height_diag;
  logic out_valid;
  logic out_stall;
  logic out_list_sel;
  logic signed [POS_W-1:0] out_pos_x;
  logic [POSY_W-1:0] out_pos_y;
  logic signed [POS_W-1:0] out_pos_z;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  vertex_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;

  height_field_mesh_vertex_emitter_top #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_col(in_col),
    .in_row(in_row),
    .in_height_here(in_height_here),
    .in_height_right(in_height_right),
    .in_height_below(in_height_below),
    .in_height_diag(in_height_diag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_list_sel(out_list_sel),
    .out_pos_x(out_pos_x),
    .out_pos_y(out_pos_y),
    .out_pos_z(out_pos_z),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: decide stall for the next edge on each falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      sb.check_vertex({out_list_sel, out_pos_x, out_pos_y, out_pos_z, out_last});
    end
  end

  // Watchdog: count cycles in which no transfer happens on any channel
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("testbench failed");
    $finish;
  end

  function automatic cell_in_t make_cell(int unsigned col, int unsigned row,
                                         int unsigned hh, int unsigned hr,
                                         int unsigned hb, int unsigned hd);
    cell_in_t c;
    c.col = col[COORD_W-1:0];
    c.row = row[COORD_W-1:0];
    c.h_here = hh[PIX_W-1:0];
    c.h_right = hr[PIX_W-1:0];
    c.h_below = hb[PIX_W-1:0];
    c.h_diag = hd[PIX_W-1:0];
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return PIX_W'($urandom_range(255));
  endfunction

  // Aim a good share of cells at the first and the closing row
  function automatic cell_in_t random_cell();
    cell_in_t c;
    int unsigned gh;
    int unsigned pick;
    gh = (sb.grid_height > MAX_DIM) ? MAX_DIM : sb.grid_height;
    pick = $urandom_range(9);
    c.col = COORD_W'($urandom_range(1023));
    if (pick < 3)
      c.row = '0;
    else if (pick < 6 && gh >= 2)
      c.row = COORD_W'(gh - 2);
    else
      c.row = COORD_W'($urandom_range(1023));
    c.h_here = random_pixel();
    c.h_right = random_pixel();
    c.h_below = random_pixel();
    c.h_diag = random_pixel();
    return c;
  endfunction

  task automatic send_cell(cell_in_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {in_col, in_row, in_height_here, in_height_right, in_height_below, in_height_diag} = c;
    do @(posedge clk); while (in_stall);
    sb.note_cell(c);
  endtask

  // Hold the sender until every expected vertex has been transferred
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(idx, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_config();
    logic [CFG_DAT_W-1:0] height_val;
    logic [CFG_DAT_W-1:0] pitch_val;
    case ($urandom_range(4))
      0: height_val = 16'd2;
      1: height_val = CFG_DAT_W'($urandom_range(3, 8));
      2: height_val = 16'd256;
      3: height_val = CFG_DAT_W'($urandom_range(0, 2047));
      default: height_val = 16'hFFFF;
    endcase
    case ($urandom_range(3))
      0: pitch_val = 16'd0;
      1: pitch_val = 16'hFFFF;
      2: pitch_val = CFG_DAT_W'($urandom_range(64, 512));
      default: pitch_val = CFG_DAT_W'($urandom);
    endcase
    write_cfg(CFG_GRID_WIDTH, CFG_DAT_W'($urandom));
    write_cfg(CFG_GRID_HEIGHT, height_val);
    write_cfg(CFG_CELL_PITCH, pitch_val);
  endtask

  task automatic run_phase(int n, int send_pct, int recv_pct, int pause_at);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    random_config();
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      send_cell(random_cell());
    end
    drain();
  endtask

  initial begin
    sb = new;
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_col, in_row, in_height_here, in_height_right, in_height_below, in_height_diag} = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Register defaults: first row, closing row, both parities, saturation
    send_cell(make_cell(0, 0, 0, 0, 0, 0));
    send_cell(make_cell(1, 0, 255, 255, 255, 255));
    send_cell(make_cell(1023, 1023, 255, 0, 128, 1));
    send_cell(make_cell(2, 254, 10, 20, 30, 40));
    send_cell(make_cell(3, 254, 200, 100, 50, 25));
    send_cell(make_cell(682, 341, 8'hAA, 8'h55, 8'h0F, 8'hF0));
    send_cell(make_cell(341, 682, 8'h55, 8'hAA, 8'hF0, 8'h0F));
    drain();

    // Two-row grid: row 0 is first and closing row at once; widest pitch
    write_cfg(CFG_GRID_WIDTH, 16'd2);
    write_cfg(CFG_GRID_HEIGHT, 16'd2);
    write_cfg(CFG_CELL_PITCH, 16'hFFFF);
    send_cell(make_cell(0, 0, 5, 6, 7, 8));
    send_cell(make_cell(1023, 0, 255, 254, 1, 0));
    send_cell(make_cell(1, 1, 3, 2, 1, 0));
    drain();

    // Height below two never closes a row; zero pitch
    write_cfg(CFG_GRID_WIDTH, 16'h0400);
    write_cfg(CFG_GRID_HEIGHT, 16'd1);
    write_cfg(CFG_CELL_PITCH, 16'd0);
    send_cell(make_cell(0, 0, 128, 64, 32, 16));
    send_cell(make_cell(1023, 1023, 17, 34, 51, 68));
    drain();

    // Height above the maximum clamps; unit pitch crosses the origin
    write_cfg(CFG_GRID_HEIGHT, 16'hFFFF);
    write_cfg(CFG_CELL_PITCH, 16'd256);
    write_cfg(CFG_SPARE, 16'h5A5A);
    send_cell(make_cell(1022, 1022, 99, 98, 97, 96));
    send_cell(make_cell(127, 127, 1, 2, 3, 4));
    send_cell(make_cell(128, 128, 250, 251, 252, 253));
    drain();

    write_cfg(CFG_GRID_HEIGHT, 16'd0);
    write_cfg(CFG_CELL_PITCH, 16'd1);
    send_cell(make_cell(0, 0, 77, 0, 255, 77));
    send_cell(make_cell(5, 1022, 11, 22, 33, 44));
    drain();

    run_phase(25, 0, 0, -1);
    run_phase(25, 63, 0, -1);
    run_phase(25, 0, 63, 12);
    run_phase(25, 23, 23, -1);

    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("Covered %0d cells and %0d vertices across %0d register writes,",
             sb.cells_noted, sb.vertices_checked, cfg_writes);
    $display("with sender gaps and receiver stalls mixed in four phases.");
    if (sb.mismatches == 0 && sb.pending_vertices.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hfmve_pkg.sv
hdl/height_field_mesh_vertex_emitter_top.sv
tb/testbench.sv
